[rtl/ntl_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntl_pkg: shared types and constants for the node table
// Holds the table depth, the command codes and the controller/datapath bus.
// ---------------------------------------------------------------------------
package ntl_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] CMD_UPDATE  = 3'd0;
    localparam logic [2:0] CMD_SET_NH  = 3'd1;
    localparam logic [2:0] CMD_GET_NH  = 3'd2;
    localparam logic [2:0] CMD_REMOVE  = 3'd3;
    localparam logic [2:0] CMD_PROTECT = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [7:0] DEFAULT_FF = 8'hFF;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic drop_victim;
        logic drop_match;
        logic insert;
        logic write_fields;
        logic set_prot;
        logic age_step;
    } t_ctl;

    typedef struct packed {
        logic             scan_last;
        logic             match;
        logic             full;
        logic [7:0]       match_nh;
    } t_sts;

endpackage

[rtl/ntl_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntl_datapath: slot storage and sequential scan
// Scans one slot per cycle for a key match, the oldest unprotected entry and
// the oldest entry overall, and a free slot. Performs inserts, drops and field writes.
// ---------------------------------------------------------------------------
module ntl_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntl_pkg::t_ctl       i_ctl,
    output ntl_pkg::t_sts       o_sts,
    input  logic [7:0]          i_role_unknown,
    input  logic [31:0]         i_node_id,
    input  logic [6:0]          i_field_mask,
    input  logic [31:0]         i_seen_time,
    input  logic [7:0]          i_next_hop_value,
    input  logic [7:0]          i_hop_count,
    input  logic [7:0]          i_channel_index,
    input  logic [7:0]          i_protocol_code,
    input  logic [7:0]          i_role_code,
    input  logic [7:0]          i_hardware_model,
    input  logic                i_protect_flag,
    output logic [31:0]         o_victim_key
);
    import ntl_pkg::*;

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [31:0] r_key   [MAX_ENTRIES];
    logic [31:0] r_seen  [MAX_ENTRIES];
    logic [7:0]  r_nh    [MAX_ENTRIES];
    logic [7:0]  r_hops  [MAX_ENTRIES];
    logic [7:0]  r_chan  [MAX_ENTRIES];
    logic [7:0]  r_proto [MAX_ENTRIES];
    logic [7:0]  r_role  [MAX_ENTRIES];
    logic [7:0]  r_hw    [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_prot;
    logic [IDX_W-1:0] r_rank [MAX_ENTRIES];
    logic [CNT_W-1:0] r_live;

    // Scan results.
    logic [IDX_W-1:0] r_ptr;
    logic             r_match;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_any_ok, r_unp_ok;
    logic [IDX_W-1:0] r_any_idx, r_unp_idx;
    logic [31:0]      r_any_seen, r_unp_seen;
    logic [IDX_W-1:0] r_any_rank, r_unp_rank;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free_idx;
    logic [IDX_W-1:0] r_drop_rank;
    logic [IDX_W-1:0] r_age_ptr;

    logic better_any, better_unp, cur_v;
    assign cur_v = r_valid[r_ptr];
    assign better_any = !r_any_ok || (r_seen[r_ptr] < r_any_seen) ||
        (r_seen[r_ptr] == r_any_seen && r_rank[r_ptr] < r_any_rank);
    assign better_unp = !r_unp_ok || (r_seen[r_ptr] < r_unp_seen) ||
        (r_seen[r_ptr] == r_unp_seen && r_rank[r_ptr] < r_unp_rank);

    logic [IDX_W-1:0] victim;
    assign victim = r_unp_ok ? r_unp_idx : r_any_idx;
    assign o_victim_key = r_key[victim];

    assign o_sts.scan_last = (r_ptr == IDX_W'(MAX_ENTRIES - 1));
    assign o_sts.match     = r_match;
    assign o_sts.full      = (r_live == CNT_W'(MAX_ENTRIES));
    assign o_sts.match_nh  = r_nh[r_match_idx];

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_clr) begin
            r_ptr <= '0;
            r_match <= 1'b0;
            r_any_ok <= 1'b0;
            r_unp_ok <= 1'b0;
            r_free_ok <= 1'b0;
            r_match_idx <= '0;
            r_any_idx <= '0;
        end else if (i_ctl.scan_step) begin
            if (!o_sts.scan_last) r_ptr <= r_ptr + 1'b1;
            if (cur_v) begin
                if (r_key[r_ptr] == i_node_id && !r_match) begin
                    r_match <= 1'b1;
                    r_match_idx <= r_ptr;
                end
                if (better_any) begin
                    r_any_ok <= 1'b1;
                    r_any_idx <= r_ptr;
                    r_any_seen <= r_seen[r_ptr];
                    r_any_rank <= r_rank[r_ptr];
                end
                if (!r_prot[r_ptr] && better_unp) begin
                    r_unp_ok <= 1'b1;
                    r_unp_idx <= r_ptr;
                    r_unp_seen <= r_seen[r_ptr];
                    r_unp_rank <= r_rank[r_ptr];
                end
            end else if (!r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free_idx <= r_ptr;
            end
        end else if (i_ctl.drop_victim) begin
            // The dropped slot becomes the first free slot candidate.
            if (!r_free_ok || victim < r_free_idx) r_free_idx <= victim;
            r_free_ok <= 1'b1;
        end
    end

    // Drop clears the valid bit (ranks are then swept down one slot a cycle); insert sets it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live <= '0;
        end else begin
            if (i_ctl.drop_victim) begin
                r_valid[victim] <= 1'b0;
                r_drop_rank <= r_rank[victim];
                r_live <= r_live - 1'b1;
            end else if (i_ctl.drop_match) begin
                r_valid[r_match_idx] <= 1'b0;
                r_drop_rank <= r_rank[r_match_idx];
                r_live <= r_live - 1'b1;
            end else if (i_ctl.insert) begin
                r_valid[r_free_idx] <= 1'b1;
                r_live <= r_live + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.drop_victim || i_ctl.drop_match) begin
            r_age_ptr <= '0;
        end else if (i_ctl.age_step) begin
            r_age_ptr <= r_age_ptr + 1'b1;
        end
    end

    // A new entry lives in the free slot found by the scan, or in the dropped slot when the table was full.
    logic [IDX_W-1:0] tgt;
    assign tgt = r_match ? r_match_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.age_step && r_valid[r_age_ptr] && r_rank[r_age_ptr] > r_drop_rank) begin
            r_rank[r_age_ptr] <= r_rank[r_age_ptr] - 1'b1;
        end
        if (i_ctl.insert) begin
            r_key[tgt]   <= i_node_id;
            r_seen[tgt]  <= '0;
            r_nh[tgt]    <= '0;
            r_hops[tgt]  <= DEFAULT_FF;
            r_chan[tgt]  <= DEFAULT_FF;
            r_proto[tgt] <= '0;
            r_role[tgt]  <= i_role_unknown;
            r_hw[tgt]    <= '0;
            r_prot[tgt]  <= 1'b0;
            r_rank[tgt]  <= r_live[IDX_W-1:0];
        end else if (i_ctl.write_fields) begin
            if (i_field_mask[0]) r_seen[tgt]  <= i_seen_time;
            if (i_field_mask[1]) r_hops[tgt]  <= i_hop_count;
            if (i_field_mask[2]) r_chan[tgt]  <= i_channel_index;
            if (i_field_mask[3]) r_nh[tgt]    <= i_next_hop_value;
            if (i_field_mask[4]) r_proto[tgt] <= i_protocol_code;
            if (i_field_mask[5]) r_role[tgt]  <= i_role_code;
            if (i_field_mask[6]) r_hw[tgt]    <= i_hardware_model;
        end else if (i_ctl.set_prot) begin
            r_prot[tgt] <= i_protect_flag;
        end
    end

endmodule

[rtl/ntl_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ntl_ctrl: command sequencer for the node table
// Captures a command, drives the scan, then the drop, insert and field
// write steps, and forms the result.
// ---------------------------------------------------------------------------
module ntl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_command,
    input  logic [31:0]       i_node_id,
    input  logic [31:0]       i_seen_time,
    input  logic [7:0]        i_next_hop_value,
    input  logic [6:0]        i_field_mask,
    output logic [6:0]        o_eff_mask,
    output ntl_pkg::t_ctl     o_ctl,
    input  ntl_pkg::t_sts     i_sts,
    input  logic [31:0]       i_victim_key,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_found,
    output logic [7:0]        o_next_hop_out,
    output logic [1:0]        o_status,
    output logic              o_evicted,
    output logic [31:0]       o_evicted_node_id
);
    import ntl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_AGE   = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_cmd;
    logic [6:0]  r_mask;
    logic        r_ins_after;
    logic [IDX_W-1:0] r_age_cnt;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_eff_mask = r_mask;

    always_comb begin
        o_ctl = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_ctl.scan_clr = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_EXEC;
            end
            S_EXEC: n_state = S_OUT;
            S_AGE: begin
                o_ctl.age_step = 1'b1;
                if (r_age_cnt == IDX_W'(MAX_ENTRIES - 1))
                    n_state = r_ins_after ? S_INS : S_OUT;
            end
            S_INS: begin
                o_ctl.insert = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_ctl.write_fields = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // Node id zero goes straight to the result with the table untouched.
        if (r_state == S_EXEC && i_node_id != 32'd0) begin
            case (r_cmd)
                CMD_UPDATE, CMD_SET_NH: begin
                    if (i_sts.match) n_state = S_WRITE;
                    else if (i_sts.full) begin
                        o_ctl.drop_victim = 1'b1;
                        n_state = S_AGE;
                    end else n_state = S_INS;
                    if (r_cmd == CMD_SET_NH &&
                        (i_sts.match ? i_sts.match_nh : 8'd0) == i_next_hop_value) begin
                        o_ctl.drop_victim = 1'b0;
                        n_state = S_OUT;
                    end
                end
                CMD_REMOVE: if (i_sts.match) begin
                    o_ctl.drop_match = 1'b1;
                    n_state = S_AGE;
                end
                CMD_PROTECT: if (i_sts.match) o_ctl.set_prot = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd <= i_command;
            r_mask <= (i_command == CMD_SET_NH) ?
                {3'b000, 1'b1, 2'b00, (i_seen_time != 32'd0)} : i_field_mask;
            o_found <= 1'b0;
            o_next_hop_out <= '0;
            o_status <= ST_DONE;
            o_evicted <= 1'b0;
            o_evicted_node_id <= '0;
        end
        if (r_state == S_SCAN && i_sts.scan_last && o_stall) begin
            // Node id zero and unused codes skip execution entirely.
            if (i_node_id == 32'd0 && r_cmd <= CMD_PROTECT) begin
                o_status <= ST_IGNORED;
            end
        end
        if (r_state == S_EXEC) begin
            r_age_cnt <= '0;
            r_ins_after <= (r_cmd != CMD_REMOVE);
            if (r_cmd <= CMD_PROTECT && o_status != ST_IGNORED) begin
                o_found <= i_sts.match;
                if (r_cmd == CMD_GET_NH && i_sts.match) o_next_hop_out <= i_sts.match_nh;
                if ((r_cmd == CMD_GET_NH || r_cmd == CMD_REMOVE || r_cmd == CMD_PROTECT)
                    && !i_sts.match) o_status <= ST_NOT_FOUND;
                if (o_ctl.drop_victim) begin
                    o_evicted <= 1'b1;
                    o_evicted_node_id <= i_victim_key;
                end
            end
        end
        if (r_state == S_AGE) r_age_cnt <= r_age_cnt + 1'b1;
    end

endmodule

[rtl/node_table_with_lru_eviction.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// node_table_with_lru_eviction: keyed neighbor table with oldest eviction
// Each command scans the table one slot per cycle; a remove, or an insert
// that evicts, then sweeps the ranks down one slot per cycle, and the insert
// and field write steps follow where the command needs them.
// One command at a time; a new transfer is taken the cycle after the result
// has left.
// Reset clears all valid bits at once and sets the unknown role to 0xFF.
// ---------------------------------------------------------------------------
module node_table_with_lru_eviction (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_node_id,
    input  logic [6:0]  i_field_mask,
    input  logic [31:0] i_seen_time,
    input  logic [7:0]  i_next_hop_value,
    input  logic [7:0]  i_hop_count,
    input  logic [7:0]  i_channel_index,
    input  logic [7:0]  i_protocol_code,
    input  logic [7:0]  i_role_code,
    input  logic [7:0]  i_hardware_model,
    input  logic        i_protect_flag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [7:0]  o_next_hop_out,
    output logic [1:0]  o_status,
    output logic        o_evicted,
    output logic [31:0] o_evicted_node_id,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import ntl_pkg::*;

    t_ctl ctl;
    t_sts sts;
    logic [7:0]  r_role_unknown;
    logic [6:0]  eff_mask;
    logic [31:0] victim_key;
    logic [2:0]  r_cmd_h;
    logic [31:0] r_id, r_seen;
    logic [7:0]  r_nh, r_hops, r_chan, r_proto, r_role, r_hw;
    logic        r_pf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role_unknown <= DEFAULT_FF;
        end else if (i_cfg_valid) begin
            r_role_unknown <= i_cfg_data;
        end
    end

    // Hold the accepted item for the length of the command.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd_h <= i_command;
            r_id <= i_node_id;
            r_seen <= i_seen_time;
            r_nh <= i_next_hop_value;
            r_hops <= i_hop_count;
            r_chan <= i_channel_index;
            r_proto <= i_protocol_code;
            r_role <= i_role_code;
            r_hw <= i_hardware_model;
            r_pf <= i_protect_flag;
        end
    end

    ntl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_node_id(r_id), .i_seen_time(i_seen_time),
        .i_next_hop_value(r_nh), .i_field_mask(i_field_mask),
        .o_eff_mask(eff_mask), .o_ctl(ctl), .i_sts(sts),
        .i_victim_key(victim_key),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_found(o_found), .o_next_hop_out(o_next_hop_out),
        .o_status(o_status), .o_evicted(o_evicted),
        .o_evicted_node_id(o_evicted_node_id)
    );

    ntl_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_ctl(ctl), .o_sts(sts),
        .i_role_unknown(r_role_unknown),
        .i_node_id(r_id), .i_field_mask(eff_mask), .i_seen_time(r_seen),
        .i_next_hop_value(r_nh), .i_hop_count(r_hops),
        .i_channel_index(r_chan), .i_protocol_code(r_proto),
        .i_role_code(r_role), .i_hardware_model(r_hw),
        .i_protect_flag(r_pf & (r_cmd_h == CMD_PROTECT)),
        .o_victim_key(victim_key)
    );

endmodule
